// ===== rtl/rgblab_pkg.sv =====
// ----------------------------------------------------------------------------
// rgblab_pkg
// Types, constants and table builders for the 8-bit sRGB to CIELAB converter.
// ----------------------------------------------------------------------------
package rgblab_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] lightness_code;
    logic [7:0] green_red_code;
    logic [7:0] blue_yellow_code;
  } lab_t;

  // linear channel values, unsigned Q0.16
  localparam int unsigned LinW = 16;
  // XYZ sums and f values, Q.30
  localparam int unsigned XyzW = 31;
  localparam int unsigned FW   = 31;

  // f table: 1026 entries at steps of 1/1024
  localparam int unsigned FRomSize  = 1026;
  localparam int unsigned FRomAw    = 11;
  localparam int unsigned FRomShift = 20;
  localparam logic [30:0] FTop = 31'(((FRomSize - 1) << FRomShift) - 1);

  // rgb to xyz matrix, Q0.14
  localparam logic [13:0] Mat [3][3] = '{
    '{14'd6757, 14'd5859,  14'd2957},
    '{14'd3483, 14'd11718, 14'd1183},
    '{14'd316,  14'd1953,  14'd15573}
  };

  // white point normalization of X (index 0) and Z (index 1)
  localparam int unsigned NrmW = 47;
  localparam logic [16:0] NrmScale = 17'd100000;
  localparam logic [16:0] NrmDen [2] = '{17'd95047, 17'd108883};
  localparam logic [16:0] NrmRnd [2] = '{17'd47523, 17'd54441};
  localparam logic [30:0] NrmRecip [2] = '{
    31'((64'd1 << 47) / 64'd95047),
    31'((64'd1 << 47) / 64'd108883)
  };

  // output code scaling
  localparam logic [12:0] LRecip  = 13'd5243;    // 2^19 / 100, rounded up
  localparam logic [17:0] AbRecip = 18'd132105;  // 2^25 / 254, rounded up

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  // linearization table entry, Q0.16
  function automatic logic [15:0] lin_entry(input int unsigned c);
    logic [63:0] cc, t, t2, lo, hi, mid, p2, p4, y, q;
    cc = 64'(c);
    lo = '0;
    hi = 64'd1 << 30;
    if (c <= 10) begin
      q = (cc * 64'd1310720 + 64'd32946) / 64'd65892;
    end else begin
      t  = (((64'd1000 * cc + 64'd14025) << 30) + 64'd134512) / 64'd269025;
      t2 = (t * t + (64'd1 << 29)) >> 30;
      for (int i = 0; i < 32; i++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          p2  = qmul(mid, mid);
          p4  = qmul(p2, p2);
          if (qmul(p4, mid) <= t2) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      y = (t2 * lo) >> 30;
      q = (y + 64'd8192) >> 14;
      if (q > 64'd65535) begin
        q = 64'd65535;
      end
    end
    return q[15:0];
  endfunction

  // cie f table entry at v = k/1024, Q.30
  function automatic logic [30:0] f_entry(input int unsigned k);
    logic [63:0] v, lo, hi, mid, r;
    v  = 64'(k) << FRomShift;
    lo = '0;
    hi = (64'd1 << 31) - 64'd1;
    if (k <= 9) begin
      r = (64'd7787 * v + 64'd500) / 64'd1000 + (((64'd16 << 30) + 64'd58) / 64'd116);
    end else begin
      for (int i = 0; i < 32; i++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (qmul(qmul(mid, mid), mid) <= v) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      r = lo;
    end
    return r[30:0];
  endfunction

endpackage

// ===== rtl/rgblab_f_rom.sv =====
// ----------------------------------------------------------------------------
// rgblab_f_rom
// Cube-root table of the CIE f function, two registered read ports at
// neighboring addresses for linear interpolation.
// ----------------------------------------------------------------------------
module rgblab_f_rom (
  input  logic                              clk_i,
  input  logic [rgblab_pkg::FRomAw-1:0]     addr_i,
  output logic [rgblab_pkg::FW-1:0]         lo_o,
  output logic [rgblab_pkg::FW-1:0]         hi_o
);

  logic [rgblab_pkg::FW-1:0]     rom [rgblab_pkg::FRomSize];
  logic [rgblab_pkg::FRomAw-1:0] addr_next;
  logic [rgblab_pkg::FW-1:0]     lo_q, hi_q;

  for (genvar k = 0; k < rgblab_pkg::FRomSize; k++) begin : g_rom
    localparam logic [rgblab_pkg::FW-1:0] Entry = rgblab_pkg::f_entry(k);
    assign rom[k] = Entry;
  end

  assign addr_next = addr_i + 1'b1;

  always_ff @(posedge clk_i) begin
    lo_q <= rom[addr_i];
    hi_q <= rom[addr_next];
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

// ===== rtl/rgb_to_lab_8bit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_lab_8bit
// sRGB to CIELAB converter, 8 bits per channel, D65 white, 2-degree observer.
//
//   port        dir  beat              qualifier
//   clk_i       in   -                 clock
//   rst_ni      in   -                 async reset, active low
//   pixel_i     in   sRGB pixel        start && !busy
//   start       in   -                 input beat request
//   busy        out  -                 always low
//   lab_o       out  Lab code triple   done_o, one cycle
//   done_o      out  -                 result strobe
//
// one pixel accepted per clock, result on done_o from the last pipeline stage
// pipeline depth is set by the white point division (reciprocal multiply split
// in partial products, then a correction step) and the registered f table read
// reset clears only the valid pipeline, the tables are constants
// the result side takes every beat, so nothing in the pipeline ever stalls
// ----------------------------------------------------------------------------
module rgb_to_lab_8bit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  rgblab_pkg::pixel_t pixel_i,
  output logic               done_o,
  output rgblab_pkg::lab_t   lab_o
);

  localparam int unsigned PipeDepth = 14;
  localparam int unsigned LinW = rgblab_pkg::LinW;
  localparam int unsigned XyzW = rgblab_pkg::XyzW;
  localparam int unsigned FW   = rgblab_pkg::FW;
  localparam int unsigned NrmW = rgblab_pkg::NrmW;

  localparam logic signed [38:0] LqOff = 39'(16) << 30;
  localparam logic signed [38:0] LqMax = 39'(100) << 30;
  localparam logic signed [41:0] AbLim = 42'(127) << 30;

  logic acc;
  logic [PipeDepth-1:0] vld_q;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeDepth-2:0], acc};
    end
  end

  // stage 1: linearization table
  logic [LinW-1:0] lin_rom [256];
  logic [LinW-1:0] lin_q [3];

  for (genvar c = 0; c < 256; c++) begin : g_lin
    localparam logic [LinW-1:0] Entry = rgblab_pkg::lin_entry(c);
    assign lin_rom[c] = Entry;
  end

  always_ff @(posedge clk_i) begin
    lin_q[0] <= lin_rom[pixel_i.red];
    lin_q[1] <= lin_rom[pixel_i.green];
    lin_q[2] <= lin_rom[pixel_i.blue];
  end

  // stage 2: matrix products, stage 3: row sums
  logic [29:0]     mp_q  [3][3];
  logic [XyzW-1:0] xyz_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mp_q[i][j] <= 30'(lin_q[j]) * 30'(rgblab_pkg::Mat[i][j]);
      end
      xyz_q[i] <= 31'(mp_q[i][0]) + 31'(mp_q[i][1]) + 31'(mp_q[i][2]);
    end
  end

  // stages 4..8: X and Z over the white point, Y delayed alongside
  // index 0 is X, index 1 is Z
  logic [NrmW-1:0] m4_q [2];
  logic [NrmW-1:0] m5_q [2];
  logic [NrmW-1:0] m6_q [2];
  logic [NrmW-1:0] m7_q [2];
  logic [53:0]     ph_q [2];
  logic [54:0]     pl_q [2];
  logic [77:0]     sum_d [2];
  logic [30:0]     qe6_q [2];
  logic [30:0]     qe7_q [2];
  logic [47:0]     pr_q [2];
  logic [NrmW-1:0] rem_d [2];
  logic [XyzW-1:0] ydl_q [4];
  logic [XyzW-1:0] nrm_q [3];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      sum_d[c] = {ph_q[c], 24'd0} + 78'(pl_q[c]);
      rem_d[c] = m7_q[c] - pr_q[c][NrmW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 2; c++) begin
      m4_q[c]  <= 47'(xyz_q[2*c]) * 47'(rgblab_pkg::NrmScale) + 47'(rgblab_pkg::NrmRnd[c]);
      ph_q[c]  <= 54'(m4_q[c][46:24]) * 54'(rgblab_pkg::NrmRecip[c]);
      pl_q[c]  <= 55'(m4_q[c][23:0]) * 55'(rgblab_pkg::NrmRecip[c]);
      m5_q[c]  <= m4_q[c];
      qe6_q[c] <= sum_d[c][77:47];
      m6_q[c]  <= m5_q[c];
      pr_q[c]  <= 48'(qe6_q[c]) * 48'(rgblab_pkg::NrmDen[c]);
      qe7_q[c] <= qe6_q[c];
      m7_q[c]  <= m6_q[c];
    end
    // estimate is at most one low
    nrm_q[0] <= qe7_q[0] + 31'(rem_d[0] >= 47'(rgblab_pkg::NrmDen[0]));
    nrm_q[2] <= qe7_q[1] + 31'(rem_d[1] >= 47'(rgblab_pkg::NrmDen[1]));
    ydl_q[0] <= xyz_q[1];
    for (int k = 1; k < 4; k++) begin
      ydl_q[k] <= ydl_q[k-1];
    end
    nrm_q[1] <= ydl_q[3];
  end

  // stage 9: clamp, table read; stage 10: slope times fraction; stage 11: add
  logic [XyzW-1:0]               vc_d   [3];
  logic [rgblab_pkg::FRomAw-1:0] f_addr [3];
  logic [FW-1:0]                 f_lo   [3];
  logic [FW-1:0]                 f_hi   [3];
  logic [19:0]                   frac_q [3];
  logic [50:0]                   ip_q   [3];
  logic [FW-1:0]                 lo_q   [3];
  logic [FW-1:0]                 f_q    [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vc_d[c]   = (nrm_q[c] > rgblab_pkg::FTop) ? rgblab_pkg::FTop : nrm_q[c];
      f_addr[c] = vc_d[c][30:20];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_fcurve
    rgblab_f_rom u_f_rom (
      .clk_i  (clk_i),
      .addr_i (f_addr[c]),
      .lo_o   (f_lo[c]),
      .hi_o   (f_hi[c])
    );
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      frac_q[c] <= vc_d[c][19:0];
      ip_q[c]   <= 51'(f_hi[c] - f_lo[c]) * 51'(frac_q[c]);
      lo_q[c]   <= f_lo[c];
      f_q[c]    <= lo_q[c] + 31'(ip_q[c] >> 20);
    end
  end

  // stage 12: L, a, b in Q.30
  logic signed [38:0] lq_q;
  logic signed [41:0] a_q, b_q;

  always_ff @(posedge clk_i) begin
    lq_q <= 39'(f_q[1]) * 39'd116 - LqOff;
    a_q  <= (42'(f_q[0]) - 42'(f_q[1])) * 42'd500;
    b_q  <= (42'(f_q[1]) - 42'(f_q[2])) * 42'd200;
  end

  // stage 13: clamp and scale, keeping the integer part
  logic [36:0]        lc_d;
  logic signed [41:0] ac_d, bc_d;
  logic [37:0]        ua_d, ub_d;
  logic [14:0]        tl_q;
  logic [15:0]        ta_q, tb_q;

  always_comb begin
    if (lq_q < 0) begin
      lc_d = '0;
    end else if (lq_q > LqMax) begin
      lc_d = LqMax[36:0];
    end else begin
      lc_d = lq_q[36:0];
    end
    if (a_q > AbLim) begin
      ac_d = AbLim;
    end else if (a_q < -AbLim) begin
      ac_d = -AbLim;
    end else begin
      ac_d = a_q;
    end
    if (b_q > AbLim) begin
      bc_d = AbLim;
    end else if (b_q < -AbLim) begin
      bc_d = -AbLim;
    end else begin
      bc_d = b_q;
    end
    ua_d = 38'(ac_d + AbLim);
    ub_d = 38'(bc_d + AbLim);
  end

  always_ff @(posedge clk_i) begin
    tl_q <= 15'((45'(lc_d) * 45'd255) >> 30) + 15'd50;
    ta_q <= 16'((46'(ua_d) * 46'd255) >> 30) + 16'd127;
    tb_q <= 16'((46'(ub_d) * 46'd255) >> 30) + 16'd127;
  end

  // stage 14: divide by 100 and 254 through reciprocals
  rgblab_pkg::lab_t lab_q;
  logic [27:0]      cl_d;
  logic [33:0]      ca_d, cb_d;

  assign cl_d = 28'(tl_q) * 28'(rgblab_pkg::LRecip);
  assign ca_d = 34'(ta_q) * 34'(rgblab_pkg::AbRecip);
  assign cb_d = 34'(tb_q) * 34'(rgblab_pkg::AbRecip);

  always_ff @(posedge clk_i) begin
    lab_q.lightness_code   <= cl_d[26:19];
    lab_q.green_red_code   <= ca_d[32:25];
    lab_q.blue_yellow_code <= cb_d[32:25];
  end

  assign lab_o  = lab_q;
  assign done_o = vld_q[PipeDepth-1];

  // a result only leaves for a beat taken the pipeline depth earlier
  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, PipeDepth))
    else $error("result strobe without an accepted pixel");

  // reciprocal quotient is never more than one low
  a_quot_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> (rem_d[0] < 47'(2 * 95047)) && (rem_d[1] < 47'(2 * 108883)))
    else $error("white point quotient estimate off by more than one");

  // f table is monotonic, so the interpolation slope is never negative
  a_slope_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> (f_hi[0] >= f_lo[0]) && (f_hi[1] >= f_lo[1]) && (f_hi[2] >= f_lo[2]))
    else $error("negative interpolation slope");

  // clamped values keep the codes within 0..255
  a_code_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[12] |-> (tl_q <= 15'd25550) && (ta_q <= 16'd64897) && (tb_q <= 16'd64897))
    else $error("scaled value outside the code range");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 8-bit sRGB to CIELAB converter. A directed table
// of corner pixels (black, white, primaries, the linear-segment boundary, bit
// patterns) is followed by random pixels with random input gaps. Expected Lab
// codes come from the directed row or from a bit-exact fixed-point model of the
// conversion, and are compared field by field with each done_o beat.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RandomPixels = 1200;
  localparam int unsigned CalmTail     = 200;
  localparam int unsigned DirectedMax  = 32;
  localparam int unsigned ExpectDepth  = DirectedMax + RandomPixels;
  localparam logic        Typed        = 1'b1;
  localparam logic        Predicted    = 1'b0;

  typedef struct packed {
    rgblab_pkg::pixel_t px;
    logic               typed_in;
    rgblab_pkg::lab_t   lab;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  rgblab_pkg::pixel_t pixel_i;
  logic               done_o;
  rgblab_pkg::lab_t   lab_o;

  logic [15:0]        lin_table [256];
  longint unsigned    cube_table [1026];
  rgblab_pkg::lab_t   lab_expect [ExpectDepth];
  int unsigned        booked_count = 0;
  int unsigned        checked_count = 0;
  stim_row_t          directed_rows [DirectedMax];
  int unsigned        row_count = 0;
  int unsigned        mismatch_count;

  rgb_to_lab_8bit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .pixel_i (pixel_i),
    .done_o  (done_o),
    .lab_o   (lab_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // fixed-point model of the conversion
  // ---------------------------------------------------------------------------

  function automatic longint unsigned q30_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // sRGB decode curve, Q0.16, via t^2.4 = t^2 * t^0.4 with a fifth-root search
  function automatic logic [15:0] srgb_decode_entry(input int unsigned c);
    longint unsigned t, t2, lo, hi, mid, p2, p4, q;
    if (c <= 10) begin
      return 16'((64'(c) * 64'd1310720 + 64'd32946) / 64'd65892);
    end
    t  = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
    t2 = (t * t + (64'd1 << 29)) >> 30;
    lo = 64'd0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      p2  = q30_mul(mid, mid);
      p4  = q30_mul(p2, p2);
      if (q30_mul(p4, mid) <= t2) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    q = (((t2 * lo) >> 30) + 64'd8192) >> 14;
    if (q > 64'd65535) begin
      q = 64'd65535;
    end
    return q[15:0];
  endfunction

  // cie f at k/1024: linear segment near zero, cube root above
  function automatic longint unsigned cube_root_entry(input int unsigned k);
    longint unsigned v, lo, hi, mid;
    v = 64'(k) << 20;
    if (k <= 9) begin
      return (64'd7787 * v + 64'd500) / 64'd1000 + ((64'd16 << 30) + 64'd58) / 64'd116;
    end
    lo = 64'd0;
    hi = (64'd1 << 31) - 64'd1;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (q30_mul(q30_mul(mid, mid), mid) <= v) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  function automatic longint unsigned cie_f(input longint unsigned v);
    longint unsigned top, idx, frac;
    top = (64'd1025 << 20) - 64'd1;
    if (v > top) begin
      v = top;
    end
    idx  = v >> 20;
    frac = v & ((64'd1 << 20) - 64'd1);
    return cube_table[idx] + (((cube_table[idx + 1] - cube_table[idx]) * frac) >> 20);
  endfunction

  // a or b in Q.30, clamped to +-127 and mapped onto 0..255
  function automatic logic [7:0] chroma_code(input longint q);
    longint lim;
    lim = 64'sd127 <<< 30;
    if (q > lim) begin
      q = lim;
    end
    if (q < -lim) begin
      q = -lim;
    end
    return 8'(($unsigned(q + lim) * 64'd255 + (64'd127 << 30)) / (64'd254 << 30));
  endfunction

  function automatic rgblab_pkg::lab_t predict_lab(input rgblab_pkg::pixel_t p);
    longint unsigned  r_lin, g_lin, b_lin, x_sum, y_sum, z_sum, fx, fy, fz;
    longint           lq;
    rgblab_pkg::lab_t res;
    r_lin = 64'(lin_table[p.red]);
    g_lin = 64'(lin_table[p.green]);
    b_lin = 64'(lin_table[p.blue]);
    x_sum = 64'd6757 * r_lin + 64'd5859 * g_lin + 64'd2957 * b_lin;
    y_sum = 64'd3483 * r_lin + 64'd11718 * g_lin + 64'd1183 * b_lin;
    z_sum = 64'd316 * r_lin + 64'd1953 * g_lin + 64'd15573 * b_lin;
    // y needs no white point division, Yn is one
    fx = cie_f((x_sum * 64'd100000 + 64'd47523) / 64'd95047);
    fy = cie_f(y_sum);
    fz = cie_f((z_sum * 64'd100000 + 64'd54441) / 64'd108883);
    lq = 64'sd116 * $signed(fy) - (64'sd16 <<< 30);
    if (lq < 0) begin
      lq = 0;
    end
    if (lq > (64'sd100 <<< 30)) begin
      lq = 64'sd100 <<< 30;
    end
    res.lightness_code   = 8'(($unsigned(lq) * 64'd255 + (64'd50 << 30)) / (64'd100 << 30));
    res.green_red_code   = chroma_code(64'sd500 * ($signed(fx) - $signed(fy)));
    res.blue_yellow_code = chroma_code(64'sd200 * ($signed(fy) - $signed(fz)));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_code(input string field, input logic [7:0] got,
                            input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
    end
  endtask

  always @(posedge clk_i) begin : check_results
    rgblab_pkg::lab_t want;
    if (rst_ni === 1'b1 && done_o !== 1'b0) begin
      if (done_o !== 1'b1) begin
        report_mismatch("done_o unknown");
      end else if (checked_count == booked_count) begin
        report_mismatch($sformatf("unexpected result beat %h", lab_o));
      end else begin
        want = lab_expect[checked_count];
        checked_count++;
        check_code("lightness", lab_o.lightness_code, want.lightness_code);
        check_code("green_red", lab_o.green_red_code, want.green_red_code);
        check_code("blue_yellow", lab_o.blue_yellow_code, want.blue_yellow_code);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic add_row(input stim_row_t r);
    directed_rows[row_count] = r;
    row_count++;
  endtask

  // holds the beat until busy is low at a rising edge, then books the result
  task automatic send_pixel(input rgblab_pkg::pixel_t px, input logic typed_in,
                            input rgblab_pkg::lab_t given);
    start   <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (busy !== 1'b0);
    lab_expect[booked_count] = typed_in ? given : predict_lab(px);
    booked_count++;
  endtask

  function automatic logic [7:0] random_channel();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(9, 12));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned        total;
    rgblab_pkg::pixel_t px;
    stim_row_t          row;
    rst_ni         = 1'b0;
    start          = 1'b0;
    pixel_i        = '0;
    mismatch_count = 0;
    for (int i = 0; i < 256; i++) begin
      lin_table[i] = srgb_decode_entry(i);
    end
    for (int k = 0; k < 1026; k++) begin
      cube_table[k] = cube_root_entry(k);
    end

    // black gives L 0 and neutral a, b
    add_row({8'd0,   8'd0,   8'd0,   Typed,     8'd0, 8'd128, 8'd128});
    add_row({8'd255, 8'd255, 8'd255, Predicted, 24'h0});
    add_row({8'd255, 8'd0,   8'd0,   Predicted, 24'h0});
    add_row({8'd0,   8'd255, 8'd0,   Predicted, 24'h0});
    add_row({8'd0,   8'd0,   8'd255, Predicted, 24'h0});
    add_row({8'd255, 8'd255, 8'd0,   Predicted, 24'h0});
    add_row({8'd0,   8'd255, 8'd255, Predicted, 24'h0});
    add_row({8'd255, 8'd0,   8'd255, Predicted, 24'h0});
    // edge of the linear segment of the decode curve
    add_row({8'd10,  8'd10,  8'd10,  Predicted, 24'h0});
    add_row({8'd11,  8'd11,  8'd11,  Predicted, 24'h0});
    add_row({8'd10,  8'd0,   8'd0,   Predicted, 24'h0});
    add_row({8'd0,   8'd11,  8'd0,   Predicted, 24'h0});
    add_row({8'd1,   8'd1,   8'd1,   Predicted, 24'h0});
    add_row({8'd0,   8'd0,   8'd1,   Predicted, 24'h0});
    add_row({8'd128, 8'd128, 8'd128, Predicted, 24'h0});
    add_row({8'd254, 8'd254, 8'd254, Predicted, 24'h0});
    // near white, normalized z just below one
    add_row({8'd255, 8'd255, 8'd254, Predicted, 24'h0});
    add_row({8'd250, 8'd255, 8'd255, Predicted, 24'h0});
    add_row({8'd85,  8'd170, 8'd85,  Predicted, 24'h0});
    add_row({8'd170, 8'd85,  8'd170, Predicted, 24'h0});
    add_row({8'd255, 8'd0,   8'd128, Predicted, 24'h0});
    add_row({8'd0,   8'd128, 8'd255, Predicted, 24'h0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    total = row_count + RandomPixels;
    for (int unsigned n = 0; n < total; n++) begin
      if (n < row_count) begin
        row = directed_rows[n];
      end else begin
        px.red   = random_channel();
        px.green = random_channel();
        px.blue  = random_channel();
        row = {px, Predicted, 24'h0};
      end
      send_pixel(row.px, row.typed_in, row.lab);
      // idle bursts, none in the last stretch so back-to-back beats are covered
      if (n + CalmTail < total && $urandom_range(0, 3) == 0) begin
        start   <= 1'b0;
        pixel_i <= rgblab_pkg::pixel_t'(24'($urandom));
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
    end
    start   <= 1'b0;
    pixel_i <= '0;

    while (checked_count != booked_count) @(posedge clk_i);
    // watch for stray beats past the pipeline depth
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rgblab_pkg.sv
rtl/rgblab_f_rom.sv
rtl/rgb_to_lab_8bit.sv
tb/tb_top.sv
